// File: rtl/core/rf_interference_detector_unit_defines.svh
// Assertion macros used by the interference detector checker.
`ifndef RF_INTERFERENCE_DETECTOR_UNIT_DEFINES_SVH
`define RF_INTERFERENCE_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RFID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RFID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define RFID_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rfid_pkg.sv
// Types and constants for the interference detector.
package rfid_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_TIMEOUT = 2'd1,
        KIND_INIT    = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // Alarm commands on the output channel
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_START = 2'd2,
        CMD_BREAK = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [1:0] REG_MARGIN   = 2'd0;
    localparam logic [1:0] REG_FF_THR   = 2'd1;
    localparam logic [1:0] REG_FIXED    = 2'd2;
    localparam logic [1:0] REG_DEFAULT  = 2'd3;

    // Mode bit positions
    localparam int unsigned MB_INT  = 0;
    localparam int unsigned MB_NFF  = 1;
    localparam int unsigned MB_TIME = 2;
    localparam int unsigned MB_BRK  = 3;
    localparam int unsigned MB_DYN  = 4;

    // Patterns of the low four mode bits
    localparam logic [3:0] MODE_IDLE     = 4'b0000;
    localparam logic [3:0] MODE_INT      = 4'b0001;
    localparam logic [3:0] MODE_INT_FF   = 4'b0011;
    localparam logic [3:0] MODE_INT_FF_T = 4'b0111;
    localparam logic [3:0] MODE_INT_FF_B = 4'b1011;

    localparam logic [9:0] OL_LIMIT = 10'd600;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] base_level;
        logic        app_active;
        logic [15:0] max_ff_count;
    } t_in_item;

    typedef struct packed {
        t_cmd        alarm_cmd;
        logic [15:0] alarm_value;
        logic        ff_flag;
        logic        time_flag;
        logic [7:0]  offset_low;
    } t_out_item;

    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [15:0] data;
    } t_cfg_wr;

endpackage

// File: rtl/core/rfid_in_reg.sv
// Input register stage of the interference detector.
module rfid_in_reg
    import rfid_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_adv,
    output logic     o_ready,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Take a new item when empty or when the held one moves on
    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/rfid_core.sv
// Detector state, configuration registers and per-item update logic.
module rfid_core
    import rfid_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_adv,
    input  t_in_item  i_item,
    output t_out_item o_res
);

    logic [15:0] r_margin;
    logic [7:0]  r_ff_thr;
    logic [15:0] r_fixed;
    logic [7:0]  r_default;

    logic [4:0]  r_mode;
    logic [15:0] r_offset;
    logic [9:0]  r_count;

    logic [4:0]  n_mode;
    logic [15:0] n_offset;
    logic [9:0]  n_count;

    logic [15:0] tick_offset;
    logic [16:0] thresh;
    logic        over;
    logic        ff_hit;
    logic [9:0]  count_inc;
    t_cmd        cmd;
    logic [15:0] val;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin  <= '0;
            r_ff_thr  <= '0;
            r_fixed   <= '0;
            r_default <= '0;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                REG_MARGIN:  r_margin  <= i_cfg.data;
                REG_FF_THR:  r_ff_thr  <= i_cfg.data[7:0];
                REG_FIXED:   r_fixed   <= i_cfg.data;
                REG_DEFAULT: r_default <= i_cfg.data[7:0];
                default:     r_margin  <= r_margin;
            endcase
        end
    end

    // Track the offset downward, then test the level against offset plus margin
    always_comb begin
        tick_offset = r_offset;
        if ((i_item.base_level != 16'd0) && r_mode[MB_DYN]
                && (i_item.base_level < r_offset)) begin
            tick_offset = {1'b0, r_offset[15:1]} + {1'b0, i_item.base_level[15:1]};
        end
        thresh    = {1'b0, tick_offset} + {1'b0, r_margin};
        over      = {1'b0, i_item.base_level} > thresh;
        ff_hit    = i_item.max_ff_count >= {8'd0, r_ff_thr};
        count_inc = r_count + 10'd1;
    end

    // Next state and result for the held item
    always_comb begin
        n_mode   = r_mode;
        n_offset = r_offset;
        n_count  = r_count;
        cmd      = CMD_NONE;
        val      = 16'd0;
        case (i_item.kind)
            KIND_TICK: begin
                n_offset = tick_offset;
                case (r_mode[3:0])
                    MODE_IDLE: begin
                        if (over) begin
                            if (i_item.app_active) begin
                                if (count_inc > OL_LIMIT) begin
                                    n_mode[MB_INT] = 1'b1;
                                    n_count        = OL_LIMIT;
                                end else begin
                                    n_count = count_inc;
                                end
                            end
                        end else begin
                            n_count = 10'd0;
                        end
                        cmd = CMD_STOP;
                    end
                    MODE_INT: begin
                        if (over) begin
                            n_count = OL_LIMIT;
                            if (ff_hit) begin
                                n_count        = 10'd0;
                                n_mode[MB_NFF] = 1'b1;
                                cmd            = CMD_START;
                                val            = i_item.max_ff_count;
                            end
                        end else if (r_count == 10'd0) begin
                            n_mode[MB_INT] = 1'b0;
                        end else begin
                            n_count = r_count - 10'd1;
                        end
                    end
                    MODE_INT_FF: begin
                        if (!ff_hit) begin
                            n_mode[MB_INT] = 1'b0;
                            n_mode[MB_NFF] = 1'b0;
                        end else if (!i_item.app_active) begin
                            n_mode[MB_BRK] = 1'b1;
                            cmd            = CMD_BREAK;
                        end
                    end
                    MODE_INT_FF_T: begin
                        if (!ff_hit) begin
                            n_mode[3:0] = 4'b0000;
                            cmd         = CMD_STOP;
                        end
                    end
                    MODE_INT_FF_B: begin
                        if (i_item.app_active) begin
                            n_mode[MB_BRK] = 1'b0;
                            cmd            = CMD_START;
                        end
                    end
                    default: begin
                        n_mode[3:0] = 4'b0000;
                    end
                endcase
            end
            KIND_TIMEOUT: begin
                n_mode[MB_TIME] = 1'b1;
            end
            KIND_INIT: begin
                n_mode  = 5'd0;
                n_count = 10'd0;
                if (r_fixed == 16'd0) begin
                    n_mode[MB_DYN] = 1'b1;
                    n_offset       = {8'd0, r_default};
                end else begin
                    n_offset = r_fixed;
                end
                cmd = CMD_STOP;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // Commit the state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_offset <= '0;
            r_count  <= '0;
        end else if (i_adv) begin
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_count  <= n_count;
        end
    end

    assign o_res.alarm_cmd   = cmd;
    assign o_res.alarm_value = val;
    assign o_res.ff_flag     = n_mode[MB_NFF];
    assign o_res.time_flag   = n_mode[MB_TIME];
    assign o_res.offset_low  = n_offset[7:0];

endmodule

// File: rtl/core/rfid_out_reg.sv
// Result register stage of the interference detector.
module rfid_out_reg
    import rfid_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_out_item i_res,
    input  logic      i_ready,
    output logic      o_room,
    output logic      o_valid,
    output t_out_item o_res
);

    logic      r_valid;
    t_out_item r_res;

    // Room when empty or when the held item is taken this cycle
    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/core/rf_interference_detector_unit.sv
// Top level of the receiver interference detector.
//
//  channel   dir  handshake            payload
//  s (in)    in   i_s_tvalid/o_s_tready tdata[39:0], tuser[1:0] kind
//  m (out)   out  o_m_tvalid/i_m_tready tdata[31:0], tuser[1:0] alarm_cmd
//  cfg       in   i_cfg_we             i_cfg_idx[1:0], i_cfg_data[15:0]
//
// Each item is held in the input register, where the offset, level test and mode
// update are worked out, and then moves on into the result register.
// Throughput is one item per cycle while the output is not stalled; the result is
// valid once its item has passed through the input register and the result register.
// Reset is synchronous and active low; it clears the mode, offset, counter,
// configuration registers and valid flags. A stall on the output holds the result and, one item later, the input.
module rf_interference_detector_unit
    import rfid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // base_level[15:0], app_active[16], max_ff_count[32:17], zero fill
    input  logic [39:0] i_s_tdata,
    // kind[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // alarm_value[15:0], ff_flag[16], time_flag[17], offset_low[25:18], zero fill
    output logic [31:0] o_m_tdata,
    // alarm_cmd[1:0]
    output logic [1:0]  o_m_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_in_item  s_item;
    t_in_item  held_item;
    logic      held_valid;
    t_out_item core_res;
    t_out_item out_res;
    logic      out_room;
    logic      adv;
    t_cfg_wr   cfg;

    // Unpack the input item
    assign s_item.kind         = t_kind'(i_s_tuser);
    assign s_item.base_level   = i_s_tdata[15:0];
    assign s_item.app_active   = i_s_tdata[16];
    assign s_item.max_ff_count = i_s_tdata[32:17];

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Advance the held item when the result register has room
    assign adv = held_valid && out_room;

    rfid_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_item  (s_item),
        .i_adv   (adv),
        .o_ready (o_s_tready),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    rfid_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (adv),
        .i_item  (held_item),
        .o_res   (core_res)
    );

    rfid_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (held_valid),
        .i_res   (core_res),
        .i_ready (i_m_tready),
        .o_room  (out_room),
        .o_valid (o_m_tvalid),
        .o_res   (out_res)
    );

    // Pack the result item
    assign o_m_tuser = out_res.alarm_cmd;
    assign o_m_tdata = {6'd0, out_res.offset_low, out_res.time_flag,
                        out_res.ff_flag, out_res.alarm_value};

endmodule

// File: rtl/core/rfid_checker.sv
// Port-level checker for the interference detector, with its bind.
`include "rf_interference_detector_unit_defines.svh"

module rfid_checker
    import rfid_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // Only a start carries an argument
    `RFID_ASSERT_NOW(a_value_only_on_start, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[15:0] != 16'd0), o_m_tuser == CMD_START, "alarm value without start")

    // A stop always leaves both flags clear
    `RFID_ASSERT_NOW(a_stop_clears_flags, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == CMD_STOP), !o_m_tdata[16] && !o_m_tdata[17], "flags set after stop")

    // A break only comes with frame failures confirmed
    `RFID_ASSERT_NOW(a_break_with_ff, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == CMD_BREAK), o_m_tdata[16], "break without frame failures")

    // A stalled result holds
    `RFID_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

    // No result straight out of reset
    `RFID_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n, !o_m_tvalid, "result valid after reset")

endmodule

bind rf_interference_detector_unit rfid_checker u_rfid_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
